/* rtl/jls_pkg.sv */
// ----------------------------------------------------------------------------
// jls_pkg
// types and constants shared by the jacobi linear solver
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

   localparam int CMD_W   = 2;
   localparam int ROW_W   = 6;
   localparam int DATA_W  = 32;
   localparam int ACC_W   = 64;
   localparam int SIZE_W  = 7;
   localparam int CHK_W   = 16;
   localparam int SWP_W   = 20;
   localparam int OUT_W   = 2;
   localparam int CSR_A_W = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD_COEF = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_VEC  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START     = 2'd2;

   localparam logic [CSR_A_W-1:0] CSR_SIZE  = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_CHECK = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_MAX   = 2'd2;

   localparam logic [OUT_W-1:0] OUT_CONVERGED = 2'd0;
   localparam logic [OUT_W-1:0] OUT_LIMIT     = 2'd1;
   localparam logic [OUT_W-1:0] OUT_ZERO_DIAG = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET  = 7'd64;
   localparam logic [CHK_W-1:0]  CHECK_RESET = 16'd1000;
   localparam logic [SWP_W-1:0]  MAX_RESET   = 20'hFFFFF;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [ROW_W-1:0]         row;
      logic [ROW_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] guess;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]         index;
      logic signed [DATA_W-1:0] solution;
      logic                     last;
      logic [OUT_W-1:0]         outcome;
      logic [SWP_W-1:0]         sweeps_done;
   } rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIAG   = 8'b0000_0010,
      ST_TEST   = 8'b0000_0100,
      ST_MAC    = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_COPY   = 8'b0010_0000,
      ST_UPDATE = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

/* rtl/jls_divider.sv */
// ----------------------------------------------------------------------------
// jls_divider
// radix-2 restoring divider, 64-bit signed numerator by 32-bit signed
// divisor, quotient truncated toward zero and saturated to 32 bits
// ----------------------------------------------------------------------------
`default_nettype none

module jls_divider
   import jls_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ACC_W-1:0]  num,
   input  wire logic [DATA_W-1:0] den,
   output logic                   done,
   output logic [DATA_W-1:0]      quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [ACC_W-1:0]  nmag_ff, nmag_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0]  q_ff, q_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] quot_ff, quot_in;

   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   rem_sub;
   logic              ge;
   logic [ACC_W-1:0]  q_nx;

   always_comb begin
      rem_sh  = {rem_ff, nmag_ff[ACC_W-1]};
      rem_sub = rem_sh - {1'b0, dmag_ff};
      ge      = rem_sh >= {1'b0, dmag_ff};
      q_nx    = {q_ff[ACC_W-2:0], ge};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nmag_in = nmag_ff;
      dmag_in = dmag_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd64;
         nmag_in = num[ACC_W-1] ? (~num + 64'd1) : num;
         dmag_in = den[DATA_W-1] ? (~den + 32'd1) : den;
         neg_in  = num[ACC_W-1] ^ den[DATA_W-1];
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         q_in    = q_nx;
         nmag_in = {nmag_ff[ACC_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               quot_in = (q_nx >= 64'h8000_0000) ? 32'h8000_0000
                                                 : (~q_nx[DATA_W-1:0] + 32'd1);
            end else begin
               quot_in = (q_nx > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_nx[DATA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

`ifndef SYNTHESIS
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_ends_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
`endif

endmodule

`default_nettype wire

/* rtl/jacobi_linear_solver_top.sv */
// ----------------------------------------------------------------------------
// jacobi_linear_solver_top
// jacobi iteration solver for A x = b in Q16.16 with a shared mac and divider
// ----------------------------------------------------------------------------
//  channel  ports              moves
//  req      req_valid/ready    load coefficient, load rhs and guess, start
//  rsp      rsp_valid/ready    one solution word per element, last on n-1
//  csr      csr_we             size_in_use, check_interval, max_sweeps
//
//  a load word is taken whenever the solver is idle; a start runs the
//  diagonal check, then per sweep a dot product through one multiplier
//  plus a 64-step divider per row, then copy, check and loop test
//  output: next word read only after the last is taken; stalls on rsp_ready hold the word
//  reset: synchronous, snapshot valid bits cleared at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_linear_solver_top
   import jls_pkg::*;
#(
   parameter int DIM = 64
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_we,
   input  wire logic [CSR_A_W-1:0] csr_index,
   input  wire logic [SWP_W-1:0]   csr_wdata
);

   localparam int IW = $clog2(DIM);
   localparam int CW = IW + 1;
   localparam int AW = $clog2(DIM * DIM);
   localparam logic [AW-1:0]     DIM_A = AW'(DIM);
   localparam logic [CW-1:0]     DIM_C = CW'(DIM);
   localparam logic [SIZE_W-1:0] DIM_S = SIZE_W'(DIM);

   logic [DATA_W-1:0] coef_mem [DIM*DIM];
   logic [DATA_W-1:0] rhs_mem  [DIM];
   logic [DATA_W-1:0] cur_mem  [DIM];
   logic [DATA_W-1:0] next_mem [DIM];
   logic [DATA_W-1:0] snap_mem [DIM];
   logic [DIM-1:0]    snap_vld_ff;

   logic [SIZE_W-1:0] size_ff;
   logic [CHK_W-1:0]  chk_ff;
   logic [SWP_W-1:0]  max_ff;

   state_type         state_ff, state_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     row_ff, row_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic              s2_vld_ff, s2_vld_in;
   logic              s2_skip_ff, s2_skip_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0] diag_ff, diag_in;
   logic              dzero_ff, dzero_in;
   logic              changed_ff, changed_in;
   logic              snap_eq_ff, snap_eq_in;
   logic              hit_ff, hit_in;
   logic [SWP_W-1:0]  sc_ff, sc_in;
   logic [CHK_W-1:0]  cnt_ff, cnt_in;
   logic [OUT_W-1:0]  outcome_ff, outcome_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] coef_rd_ff, cur_rd_ff;
   logic [DATA_W-1:0] next_rd_ff, snap_rd_ff, rhs_rd_ff;
   logic              snap_rv_ff;

   logic [AW-1:0]     coef_raddr, coef_waddr;
   logic              coef_we, vec_we, cur_cp_we, snap_we, next_we;
   logic              issue, drained;
   logic [DATA_W-1:0] snap_val;
   logic              div_start, div_done;
   logic [DATA_W-1:0] div_quot;
   logic [ACC_W-1:0]  numer;
   logic [SWP_W-1:0]  sc1;
   logic [CHK_W-1:0]  r_nx;
   logic [CHK_W-1:0]  gap;
   logic [SWP_W:0]    target;
   logic              req_fire;
   logic [IW-1:0]     idx_a, row_a;

   jls_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (numer),
      .den   (diag_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         chk_ff  <= CHECK_RESET;
         max_ff  <= MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIZE:  size_ff <= csr_wdata[SIZE_W-1:0];
            CSR_CHECK: chk_ff  <= csr_wdata[CHK_W-1:0];
            CSR_MAX:   max_ff  <= csr_wdata;
            default:   ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign idx_a     = idx_ff[IW-1:0];
   assign row_a     = row_ff[IW-1:0];
   assign snap_val  = snap_rv_ff ? snap_rd_ff : '0;
   assign numer     = ({{(ACC_W-DATA_W){rhs_rd_ff[DATA_W-1]}}, rhs_rd_ff} << 16) - acc_ff;
   assign coef_raddr = (state_ff == ST_DIAG) ? (AW'(idx_a) * DIM_A + AW'(idx_a))
                                             : (AW'(row_a) * DIM_A + AW'(idx_a));
   assign coef_waddr = AW'(req_data.row) * DIM_A + AW'(req_data.col);
   assign drained    = (idx_ff == n_ff) && !rd_vld_ff && !s2_vld_ff;
   assign sc1        = sc_ff + 20'd1;
   assign r_nx       = hit_ff ? '0 : (cnt_ff + 16'd1);
   assign gap        = chk_ff - 16'd1 - r_nx;

   always_comb begin
      if (chk_ff == '0) begin
         target = {1'b0, max_ff};
      end else begin
         target = {1'b0, sc1} + (SWP_W+1)'(gap);
         if (target > {1'b0, max_ff}) begin
            target = {1'b0, max_ff};
         end
      end
   end

   always_comb begin
      case (state_ff)
         ST_DIAG, ST_MAC, ST_COPY: issue = idx_ff < n_ff;
         ST_EMIT: issue = (idx_ff < n_ff) && !rd_vld_ff && !rsp_valid_ff;
         default: issue = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      idx_in       = issue ? idx_ff + 1'b1 : idx_ff;
      row_in       = row_ff;
      rd_vld_in    = issue;
      rd_idx_in    = idx_a;
      s2_vld_in    = rd_vld_ff && (state_ff == ST_MAC);
      s2_skip_in   = rd_idx_ff == row_a;
      prod_in      = coef_rd_ff * cur_rd_ff;
      acc_in       = (s2_vld_ff && !s2_skip_ff) ? acc_ff + prod_ff : acc_ff;
      diag_in      = diag_ff;
      dzero_in     = dzero_ff;
      changed_in   = changed_ff;
      snap_eq_in   = snap_eq_ff;
      hit_in       = hit_ff;
      sc_in        = sc_ff;
      cnt_in       = cnt_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      coef_we      = 1'b0;
      vec_we       = 1'b0;
      cur_cp_we    = 1'b0;
      snap_we      = 1'b0;
      next_we      = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.cmd)
                  CMD_LOAD_COEF: coef_we = ({1'b0, req_data.row} < (ROW_W+1)'(DIM))
                                        && ({1'b0, req_data.col} < (ROW_W+1)'(DIM));
                  CMD_LOAD_VEC:  vec_we = {1'b0, req_data.row} < (ROW_W+1)'(DIM);
                  CMD_START: begin
                     if (size_ff == '0) begin
                        n_in = CW'(1);
                     end else if (size_ff > DIM_S) begin
                        n_in = DIM_C;
                     end else begin
                        n_in = CW'(size_ff);
                     end
                     sc_in      = '0;
                     cnt_in     = '0;
                     outcome_in = OUT_LIMIT;
                     idx_in     = '0;
                     dzero_in   = 1'b0;
                     state_in   = ST_DIAG;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIAG: begin
            if (rd_vld_ff && (coef_rd_ff == '0)) begin
               dzero_in = 1'b1;
            end
            if (drained) begin
               idx_in = '0;
               if (dzero_ff) begin
                  outcome_in = OUT_ZERO_DIAG;
                  state_in   = ST_EMIT;
               end else begin
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            idx_in = '0;
            if (sc_ff < max_ff) begin
               row_in   = '0;
               acc_in   = '0;
               state_in = ST_MAC;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MAC: begin
            if (rd_vld_ff && (rd_idx_ff == row_a)) begin
               diag_in = coef_rd_ff;
            end
            if (drained) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               next_we = 1'b1;
               idx_in  = '0;
               acc_in  = '0;
               if (row_ff + 1'b1 == n_ff) begin
                  changed_in = 1'b0;
                  snap_eq_in = 1'b1;
                  hit_in     = (chk_ff != '0)
                            && (({1'b0, cnt_ff} + 17'd1) == {1'b0, chk_ff});
                  state_in   = ST_COPY;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = ST_MAC;
               end
            end
         end
         ST_COPY: begin
            if (rd_vld_ff) begin
               cur_cp_we = 1'b1;
               snap_we   = hit_ff;
               if (next_rd_ff != cur_rd_ff) begin
                  changed_in = 1'b1;
               end
               if (next_rd_ff != snap_val) begin
                  snap_eq_in = 1'b0;
               end
            end
            if (drained) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            idx_in = '0;
            if (hit_ff && snap_eq_ff) begin
               outcome_in = OUT_CONVERGED;
               sc_in      = sc1;
               state_in   = ST_EMIT;
            end else if (!changed_ff) begin
               sc_in    = target[SWP_W-1:0];
               cnt_in   = chk_ff - 16'd1;
               state_in = ST_TEST;
            end else begin
               sc_in    = sc1;
               cnt_in   = r_nx;
               state_in = ST_TEST;
            end
         end
         ST_EMIT: begin
            if (rd_vld_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.index       = ROW_W'(rd_idx_ff);
               rsp_in.solution    = cur_rd_ff;
               rsp_in.last        = (CW'(rd_idx_ff) + 1'b1) == n_ff;
               rsp_in.outcome     = outcome_ff;
               rsp_in.sweeps_done = sc_ff;
               if ((CW'(rd_idx_ff) + 1'b1) == n_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         n_ff         <= DIM_C;
         sc_ff        <= '0;
         cnt_ff       <= '0;
         outcome_ff   <= OUT_LIMIT;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         sc_ff        <= sc_in;
         cnt_ff       <= cnt_in;
         outcome_ff   <= outcome_in;
      end
      row_ff     <= row_in;
      rd_idx_ff  <= rd_idx_in;
      s2_skip_ff <= s2_skip_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      diag_ff    <= diag_in;
      dzero_ff   <= dzero_in;
      changed_ff <= changed_in;
      snap_eq_ff <= snap_eq_in;
      hit_ff     <= hit_in;
      rsp_ff     <= rsp_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_data.value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         rhs_mem[req_data.row[IW-1:0]] <= req_data.value;
      end
      rhs_rd_ff <= rhs_mem[row_a];
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         cur_mem[req_data.row[IW-1:0]] <= req_data.guess;
      end else if (cur_cp_we) begin
         cur_mem[rd_idx_ff] <= next_rd_ff;
      end
      cur_rd_ff <= cur_mem[idx_a];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[row_a] <= div_quot;
      end
      next_rd_ff <= next_mem[idx_a];
   end

   always_ff @(posedge clock) begin
      if (snap_we) begin
         snap_mem[rd_idx_ff] <= next_rd_ff;
      end
      snap_rd_ff <= snap_mem[idx_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_vld_ff <= '0;
         snap_rv_ff  <= 1'b0;
      end else begin
         if (snap_we) begin
            snap_vld_ff[rd_idx_ff] <= 1'b1;
         end
         snap_rv_ff <= snap_vld_ff[idx_a];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_div_in_div : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("divider result outside divide");
   a_sweeps_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> sc_ff <= max_ff) else $error("sweep count past limit");
   a_zero_diag_no_sweep : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.outcome == OUT_ZERO_DIAG) |-> rsp_ff.sweeps_done == '0)
      else $error("zero diagonal word with sweeps");
   a_mac_drained : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !s2_vld_ff && !rd_vld_ff) else $error("divide started mid dot product");
`endif

endmodule

`default_nettype wire
